/* src/slt_pkg.sv */
// ----------------------------------------------------------------------------
// slt_pkg: shared types and constants of the sorted list table
// sizes, request and status codes, and the command broadcast to the cell row
// ----------------------------------------------------------------------------
package slt_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int ACT_W    = 2;
  localparam int STAT_W   = 2;
  localparam int ECNT_W   = 5;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DELETE = 2'd2;

  localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

  typedef enum logic [1:0] {
    UPD_HOLD,
    UPD_INS,
    UPD_DEL
  } upd_t;

  typedef struct packed {
    upd_t                     upd;
    logic signed [VAL_W-1:0]  key;
  } cell_cmd_t;

endpackage

/* src/slt_cell.sv */
// ----------------------------------------------------------------------------
// slt_cell: one position of the sorted row
// holds one entry, compares it against the broadcast key and takes its left
// neighbor on insert or its right neighbor on delete
// ----------------------------------------------------------------------------
module slt_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  slt_pkg::cell_cmd_t                cmd,
  input  logic signed [slt_pkg::VAL_W-1:0]  left_val,
  input  logic                              left_vld,
  input  logic                              left_lt,
  input  logic signed [slt_pkg::VAL_W-1:0]  right_val,
  input  logic                              right_vld,
  output logic signed [slt_pkg::VAL_W-1:0]  val,
  output logic                              vld,
  output logic                              lt,
  output logic                              eq
);

  logic signed [slt_pkg::VAL_W-1:0] val_r;
  logic signed [slt_pkg::VAL_W-1:0] val_nxt;
  logic                             vld_r;
  logic                             vld_nxt;

  assign lt  = vld_r && (val_r < cmd.key);
  assign eq  = vld_r && (val_r == cmd.key);
  assign val = val_r;
  assign vld = vld_r;

  always_comb begin
    val_nxt = val_r;
    vld_nxt = vld_r;
    case (cmd.upd)
      slt_pkg::UPD_INS: begin
        // this cell and all above it move up; the first such cell takes the key
        if (!lt) begin
          if (!left_lt) begin
            val_nxt = left_val;
            vld_nxt = left_vld;
          end else begin
            val_nxt = cmd.key;
            vld_nxt = 1'b1;
          end
        end
      end
      slt_pkg::UPD_DEL: begin
        if (vld_r && !lt) begin
          val_nxt = right_val;
          vld_nxt = right_vld;
        end
      end
      default: begin
        val_nxt = val_r;
        vld_nxt = vld_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    val_r <= val_nxt;
  end

endmodule

/* src/slt_chain.sv */
// ----------------------------------------------------------------------------
// slt_chain: row of sorted cells
// links each cell to its neighbors and gathers the match flags of the row
// ----------------------------------------------------------------------------
module slt_chain (
  input  logic               clk,
  input  logic               rst_n,
  input  slt_pkg::cell_cmd_t cmd,
  output logic               found
);

  logic signed [slt_pkg::VAL_W-1:0] cval [slt_pkg::CAPACITY];
  logic [slt_pkg::CAPACITY-1:0]     cvld;
  logic [slt_pkg::CAPACITY-1:0]     clt;
  logic [slt_pkg::CAPACITY-1:0]     ceq;

  for (genvar i = 0; i < slt_pkg::CAPACITY; i++) begin : g_cell
    logic signed [slt_pkg::VAL_W-1:0] lval;
    logic                             lvld;
    logic                             llt;
    logic signed [slt_pkg::VAL_W-1:0] rval;
    logic                             rvld;

    if (i == 0) begin : g_head
      // nothing to the left: treated as smaller than any key
      assign lval = '0;
      assign lvld = 1'b0;
      assign llt  = 1'b1;
    end else begin : g_mid_l
      assign lval = cval[i-1];
      assign lvld = cvld[i-1];
      assign llt  = clt[i-1];
    end

    if (i == slt_pkg::CAPACITY - 1) begin : g_tail
      assign rval = '0;
      assign rvld = 1'b0;
    end else begin : g_mid_r
      assign rval = cval[i+1];
      assign rvld = cvld[i+1];
    end

    slt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .left_val  (lval),
      .left_vld  (lvld),
      .left_lt   (llt),
      .right_val (rval),
      .right_vld (rvld),
      .val       (cval[i]),
      .vld       (cvld[i]),
      .lt        (clt[i]),
      .eq        (ceq[i])
    );
  end

  assign found = |ceq;

endmodule

/* src/sorted_list_table.sv */
// ----------------------------------------------------------------------------
// sorted_list_table: bounded table of signed values kept in ascending order
// one request at a time: insert, search or delete of the first equal entry
// ----------------------------------------------------------------------------
//   A request is taken on a rising edge where start is high and busy is low;
//   in_action picks insert, search or delete and in_value carries the value.
//   The entries live in a row of cells, each holding one value and a valid
//   bit. All cells compare against the request value at once, and on an
//   insert or delete every cell at or past the target position takes its
//   left or right neighbor in the same cycle.
//   The request is held in the request registers, the row compares and shifts,
//   and the result is registered: out_valid then holds it on out_status and
//   out_entry_count for a single cycle. busy stays high until that result is
//   registered, so a new request is not taken before the previous one is done;
//   the limit is the compare-and-shift step of the row after the request register.
//   The receiver cannot stall: each result is shown once and must be taken.
//   Reset (synchronous, rst_n low) empties the table and drops any request
//   in flight; entry values themselves are not cleared.
//   Status: done or found, not found, or full (insert dropped).
// ----------------------------------------------------------------------------
module sorted_list_table (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [slt_pkg::ACT_W-1:0]         in_action,
  input  logic signed [slt_pkg::VAL_W-1:0]  in_value,
  output logic                              out_valid,
  output logic [slt_pkg::STAT_W-1:0]        out_status,
  output logic [slt_pkg::ECNT_W-1:0]        out_entry_count
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t                            state_r;
  state_t                            state_nxt;
  logic [slt_pkg::ACT_W-1:0]         act_r;
  logic [slt_pkg::ACT_W-1:0]         act_nxt;
  logic signed [slt_pkg::VAL_W-1:0]  key_r;
  logic signed [slt_pkg::VAL_W-1:0]  key_nxt;
  logic [slt_pkg::CNT_W-1:0]         count_r;
  logic [slt_pkg::CNT_W-1:0]         count_nxt;
  logic                              out_valid_r;
  logic                              out_valid_nxt;
  logic [slt_pkg::STAT_W-1:0]        out_status_r;
  logic [slt_pkg::STAT_W-1:0]        out_status_nxt;
  logic [slt_pkg::ECNT_W-1:0]        out_cnt_r;
  logic [slt_pkg::ECNT_W-1:0]        out_cnt_nxt;

  slt_pkg::cell_cmd_t cmd;
  logic               found;
  logic               full;

  assign full = (count_r == slt_pkg::CNT_W'(slt_pkg::CAPACITY));

  slt_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .found (found)
  );

  always_comb begin
    cmd.key = key_r;
    cmd.upd = slt_pkg::UPD_HOLD;
    if (state_r == S_EXEC) begin
      case (act_r)
        slt_pkg::ACT_INSERT: if (!full) cmd.upd = slt_pkg::UPD_INS;
        slt_pkg::ACT_DELETE: if (found) cmd.upd = slt_pkg::UPD_DEL;
        default:             cmd.upd = slt_pkg::UPD_HOLD;
      endcase
    end
  end

  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    key_nxt        = key_r;
    count_nxt      = count_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_cnt_nxt    = out_cnt_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          act_nxt   = in_action;
          key_nxt   = in_value;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (act_r)
          slt_pkg::ACT_INSERT: begin
            if (full) begin
              out_status_nxt = slt_pkg::ST_FULL;
            end else begin
              out_status_nxt = slt_pkg::ST_DONE;
              count_nxt      = count_r + slt_pkg::CNT_W'(1);
            end
          end
          slt_pkg::ACT_SEARCH: begin
            out_status_nxt = found ? slt_pkg::ST_DONE : slt_pkg::ST_NOT_FOUND;
          end
          slt_pkg::ACT_DELETE: begin
            if (found) begin
              out_status_nxt = slt_pkg::ST_DONE;
              count_nxt      = count_r - slt_pkg::CNT_W'(1);
            end else begin
              out_status_nxt = slt_pkg::ST_NOT_FOUND;
            end
          end
          default: out_status_nxt = slt_pkg::ST_NOT_FOUND;
        endcase
        out_cnt_nxt   = slt_pkg::ECNT_W'(count_nxt);
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    act_r        <= act_nxt;
    key_r        <= key_nxt;
    out_status_r <= out_status_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_cnt_r;

endmodule

/* src/slt_checker.sv */
// ----------------------------------------------------------------------------
// slt_checker: port-level checks of the sorted list table
// request to result timing and consistency of the reported count
// ----------------------------------------------------------------------------
module slt_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              busy,
  input  logic [slt_pkg::ACT_W-1:0]         in_action,
  input  logic                              out_valid,
  input  logic [slt_pkg::STAT_W-1:0]        out_status,
  input  logic [slt_pkg::ECNT_W-1:0]        out_entry_count
);

  // a result only ever follows a request that was taken
  a_result_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without a matching request");

  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("request taken but block not busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == slt_pkg::ST_FULL) |->
      (out_entry_count == slt_pkg::ECNT_W'(slt_pkg::CAPACITY)))
    else $error("full status with table not full");

  // an insert that succeeds never reports an empty table
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == slt_pkg::ST_DONE &&
     $past(in_action, 2) == slt_pkg::ACT_INSERT) |->
      (out_entry_count != 5'd0))
    else $error("insert done but table reports empty");

endmodule

bind sorted_list_table slt_checker u_slt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_action       (in_action),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_entry_count (out_entry_count)
);
